### sv/atap_pkg.sv
// atap_pkg: shared widths, types and codes for the allpass chain interpolating tap
// no dependencies; imported by allpass_chain_interp_tap, atap_weights and atap_checker

package atap_pkg;

  localparam int MAX_STAGES_DEF = 256;
  localparam int MIN_STAGES     = 3;
  localparam int TAPS           = 4;

  localparam int SAMPLE_W    = 24;
  localparam int POS_W       = 24;
  localparam int FRAC_W      = 16;
  localparam int POS_INT_W   = POS_W - FRAC_W;
  localparam int COEF_W      = 17;
  localparam int COUNT_W     = 9;
  localparam int CFG_W       = 17;
  localparam int WORD_W      = 32;
  localparam int WEIGHT_W    = 26;
  localparam int WEIGHT_FRAC = 24;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [TAPS-1:0] weight_vec_t;

  typedef enum logic {
    CFG_COEFFICIENT = 1'b0,
    CFG_STAGE_COUNT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_SWEEP_LAST,
    ST_TAIL,
    ST_TAP,
    ST_TAP_WAIT
  } state_t;

endpackage

### sv/allpass_chain_interp_tap.sv
// allpass_chain_interp_tap: per input transaction, a single ram pass over words 0..n, n = clamped
// stage count, then four tap reads; no new input is taken until the result is loaded and the
// block is idle again. reset (rst, synchronous) clears the control state and starts a clearing
// pass over all MAX_STAGES+1 words of the chain ram; no input is taken during it, configuration is.
// depends on atap_pkg, atap_ram, atap_weights

module allpass_chain_interp_tap #(
  parameter int MAX_STAGES = atap_pkg::MAX_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [atap_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [atap_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // sample_in, tap_position
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [atap_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // sample_out
);
  import atap_pkg::*;

  localparam int DEPTH = MAX_STAGES + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SEC_W = COEF_W + WORD_W + 1;
  localparam int SUM_W = WORD_W + 3;
  localparam int PRD_W = WEIGHT_W + WORD_W;
  localparam int ACC_W = PRD_W + 2;
  localparam int SH_W  = ACC_W - WEIGHT_FRAC;

  localparam logic signed [SEC_W-1:0] SEC_HALF = SEC_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(32'sh7fffffff);
  localparam logic signed [SUM_W-1:0] SUM_MIN  = -SUM_MAX - SUM_W'(1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (WEIGHT_FRAC - 1);
  localparam logic signed [SH_W-1:0]  OUT_MAX  = SH_W'(24'sh7fffff);
  localparam logic signed [SH_W-1:0]  OUT_MIN  = -OUT_MAX - SH_W'(1);

  state_t state, state_next;

  logic signed [COEF_W-1:0]   coef;
  logic [COUNT_W-1:0]         stage_cnt;
  logic [AW-1:0]              cnt, cnt_next;
  logic [1:0]                 tj, tj_next;
  logic                       rv, tv, pv;
  logic [AW-1:0]              raq;
  logic [1:0]                 tjq;
  logic [AW-1:0]              n_r, di_r;
  logic [FRAC_W-1:0]          frac_r;
  logic signed [WORD_W-1:0]   cur, prev;
  logic signed [PRD_W-1:0]    prod;
  logic signed [ACC_W-1:0]    acc;
  logic                       out_valid;
  logic [OUT_TDATA_W-1:0]     out_data;

  logic                       s_accept, load_out, sweep_wr;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [WORD_W-1:0]          ram_wdata, rdata;
  weight_vec_t                w_vec;

  logic [COUNT_W-1:0]         n_clamp, di_lim, pos_int, di_clamp;
  logic signed [WORD_W:0]     diff;
  logic signed [SEC_W-1:0]    sec_prod;
  logic signed [SEC_W-1:0]    sec_rnd;
  logic signed [SUM_W-1:0]    sec_sum;
  logic signed [WORD_W-1:0]   sec_out;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [SH_W-1:0]     acc_sh;
  logic [OUT_TDATA_W-1:0]     out_sat;

  atap_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  atap_weights u_weights (
    .clk (clk),
    .frac(frac_r),
    .w   (w_vec)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef      <= '0;
      stage_cnt <= COUNT_W'(MIN_STAGES);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_COEFFICIENT: coef      <= $signed(cfg_data[COEF_W-1:0]);
        CFG_STAGE_COUNT: stage_cnt <= cfg_data[COUNT_W-1:0];
        default:         coef      <= coef;
      endcase
    end
  end

  // stage count and tap index clamps
  always_comb begin
    if (stage_cnt < COUNT_W'(MIN_STAGES)) begin
      n_clamp = COUNT_W'(MIN_STAGES);
    end else if (stage_cnt > COUNT_W'(MAX_STAGES)) begin
      n_clamp = COUNT_W'(MAX_STAGES);
    end else begin
      n_clamp = stage_cnt;
    end
    di_lim   = n_clamp - COUNT_W'(MIN_STAGES);
    pos_int  = COUNT_W'(s_axis_tdata[IN_TDATA_W-1 -: POS_INT_W]);
    di_clamp = (pos_int > di_lim) ? di_lim : pos_int;
  end

  // allpass section on the word just read
  always_comb begin
    diff     = {rdata[WORD_W-1], rdata} - {cur[WORD_W-1], cur};
    sec_prod = coef * diff;
    sec_rnd  = sec_prod + SEC_HALF;
    sec_sum  = SUM_W'($signed(sec_rnd[SEC_W-1:FRAC_W])) + SUM_W'(prev);
    if (sec_sum > SUM_MAX) begin
      sec_out = SUM_MAX[WORD_W-1:0];
    end else if (sec_sum < SUM_MIN) begin
      sec_out = SUM_MIN[WORD_W-1:0];
    end else begin
      sec_out = sec_sum[WORD_W-1:0];
    end
  end

  // tap sum rounding and saturation
  always_comb begin
    acc_rnd = acc + ACC_HALF;
    acc_sh  = acc_rnd[ACC_W-1:WEIGHT_FRAC];
    if (acc_sh > OUT_MAX) begin
      out_sat = OUT_MAX[OUT_TDATA_W-1:0];
    end else if (acc_sh < OUT_MIN) begin
      out_sat = OUT_MIN[OUT_TDATA_W-1:0];
    end else begin
      out_sat = acc_sh[OUT_TDATA_W-1:0];
    end
  end

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign sweep_wr = rv && (raq != '0);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    tj_next       = tj;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = raq - AW'(1);
    ram_wdata     = cur;
    ram_raddr     = cnt;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
        cnt_next  = cnt + AW'(1);
        if (cnt == AW'(MAX_STAGES)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cnt_next   = '0;
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        ram_we   = sweep_wr;
        cnt_next = cnt + AW'(1);
        if (cnt == n_r) begin
          state_next = ST_SWEEP_LAST;
        end
      end
      ST_SWEEP_LAST: begin
        ram_we     = sweep_wr;
        state_next = ST_TAIL;
      end
      ST_TAIL: begin
        ram_we     = 1'b1;
        ram_waddr  = n_r;
        tj_next    = '0;
        state_next = ST_TAP;
      end
      ST_TAP: begin
        ram_raddr = di_r + AW'(tj);
        tj_next   = tj + 2'd1;
        if (tj == 2'(TAPS - 1)) begin
          state_next = ST_TAP_WAIT;
        end
      end
      ST_TAP_WAIT: begin
        if (!tv && !pv && (!out_valid || m_axis_tready)) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      tj        <= '0;
      rv        <= 1'b0;
      tv        <= 1'b0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      tj  <= tj_next;
      rv  <= (state == ST_SWEEP);
      tv  <= (state == ST_TAP);
      pv  <= tv;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    raq  <= cnt;
    tjq  <= tj;
    prod <= w_vec[tjq] * $signed(rdata);
    if (s_accept) begin
      cur    <= WORD_W'($signed(s_axis_tdata[SAMPLE_W-1:0]));
      n_r    <= AW'(n_clamp);
      di_r   <= AW'(di_clamp);
      frac_r <= s_axis_tdata[SAMPLE_W +: FRAC_W];
      acc    <= '0;
    end
    if (rv) begin
      prev <= $signed(rdata);
      if (raq != '0) begin
        cur <= sec_out;
      end
    end
    if (pv) begin
      acc <= acc + ACC_W'(prod);
    end
    if (load_out) begin
      out_data <= out_sat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

### sv/atap_ram.sv
// atap_ram: generic single-clock ram, one write port and one registered read port
// no dependencies

module atap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/atap_weights.sv
// atap_weights: five-stage pipeline for the cubic lagrange weights in q.24
// depends on atap_pkg; w is the registered output of the last stage

module atap_weights (
  input  logic                      clk,
  input  logic [atap_pkg::FRAC_W-1:0] frac,
  output atap_pkg::weight_vec_t     w
);
  import atap_pkg::*;

  localparam int PW      = FRAC_W + 3;
  localparam int PRD_W   = 2 * PW;
  localparam int C_W     = 3 * PW;
  localparam int T_W     = 30;
  localparam int RCP_W   = 31;
  localparam int RSH     = 33;
  localparam int M_W     = T_W + RCP_W;
  localparam int Q_W     = M_W - RSH;
  localparam logic signed [PW-1:0]  ONE     = PW'(1) <<< FRAC_W;
  localparam logic signed [PW-1:0]  TWO     = PW'(2) <<< FRAC_W;
  localparam logic signed [C_W-1:0] HALF_DEN = C_W'(3) <<< WEIGHT_FRAC;
  localparam logic signed [T_W-1:0] OFFSET6 = T_W'(6) <<< 25;
  localparam logic signed [Q_W:0]   OFFSET  = (Q_W+1)'(1) <<< 25;
  localparam logic [RCP_W-1:0]      RECIP   = 31'd1431655766;

  logic signed [PW-1:0]    d_s, dm1_s, dp1_s, dm2_s;
  logic signed [PW-1:0]    d1, dm1_1, dp1_1, dm2_1;
  logic signed [PRD_W-1:0] p1, q1;
  logic signed [C_W-1:0]   prod_a, prod_b, prod_c, prod_d;
  logic signed [C_W-1:0]   c2 [TAPS];
  logic signed [C_W-1:0]   csum [TAPS];
  logic signed [T_W-1:0]   tsh [TAPS];
  logic [T_W-1:0]          tt3 [TAPS];
  logic [M_W-1:0]          m4 [TAPS];
  logic signed [Q_W:0]     wq [TAPS];

  // nodes at -1, 0, 1, 2 in q.16
  always_comb begin
    d_s   = $signed(PW'(frac));
    dm1_s = d_s - ONE;
    dp1_s = d_s + ONE;
    dm2_s = d_s - TWO;
  end

  always_ff @(posedge clk) begin
    d1    <= d_s;
    dm1_1 <= dm1_s;
    dp1_1 <= dp1_s;
    dm2_1 <= dm2_s;
    p1    <= d_s * dm1_s;
    q1    <= dp1_s * dm2_s;
  end

  always_comb begin
    prod_a = p1 * dm2_1;
    prod_b = dm1_1 * q1;
    prod_c = d1 * q1;
    prod_d = dp1_1 * p1;
  end

  // numerators scaled by 6 * 2^48
  always_ff @(posedge clk) begin
    c2[0] <= -prod_a;
    c2[1] <= prod_b + (prod_b <<< 1);
    c2[2] <= -(prod_c + (prod_c <<< 1));
    c2[3] <= prod_d;
  end

  // floor((c + 3*2^24) / 2^24), offset to stay positive for the divide by six
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      csum[i] = c2[i] + HALF_DEN;
      tsh[i]  = csum[i][WEIGHT_FRAC +: T_W];
      wq[i]   = $signed({1'b0, m4[i][RSH +: Q_W]}) - OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TAPS; i++) begin
      tt3[i] <= T_W'(tsh[i] + OFFSET6);
      m4[i]  <= tt3[i] * RECIP;
      w[i]   <= wq[i][WEIGHT_W-1:0];
    end
  end

endmodule

### sv/atap_checker.sv
// atap_checker: port-level assertions for allpass_chain_interp_tap, bound to the top level
// depends on atap_pkg and allpass_chain_interp_tap

module atap_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [atap_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import atap_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // clearing pass holds off input after reset
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  // one item in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_axis_tready)
    else $error("second transaction taken while busy");

  // no result right after an input transaction
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // a new result frees the input side
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result without return to idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind allpass_chain_interp_tap atap_checker u_atap_checker (.*);
